>>> src/two_button_debounce_chord_defines.svh
// Assertion macros used by the debouncer core (tbdc_core).
`ifndef TWO_BUTTON_DEBOUNCE_CHORD_DEFINES_SVH
`define TWO_BUTTON_DEBOUNCE_CHORD_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TBDC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TBDC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TBDC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TBDC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/tbdc_pkg.sv
`timescale 1ns / 1ps
package tbdc_pkg;

  localparam logic       REG_DIVIDER_RELOAD   = 1'b0;
  localparam logic       REG_FILTER_LIMIT     = 1'b1;
  localparam logic [7:0] DIVIDER_RELOAD_RESET = 8'd10;
  localparam logic [7:0] FILTER_LIMIT_RESET   = 8'd5;

  typedef struct packed {
    logic tick;
    logic up_level;
    logic down_level;
  } in_item_t;

  typedef struct packed {
    logic up_held;
    logic down_held;
    logic open_pulse;
    logic close_pulse;
    logic toggle_pulse;
    logic chord_held;
  } out_item_t;

  typedef struct packed {
    logic [7:0] divider_reload;
    logic [7:0] filter_limit;
  } cfg_t;

endpackage

>>> src/tbdc_in_reg.sv
`timescale 1ns / 1ps
module tbdc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tbdc_pkg::in_item_t in_data,
  output logic              s_valid,
  input  logic              s_ready,
  output tbdc_pkg::in_item_t s_data
);
  import tbdc_pkg::*;

  assign in_ready = !s_valid || s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data <= in_data;
    end
  end

endmodule

>>> src/tbdc_core.sv
`timescale 1ns / 1ps
`include "two_button_debounce_chord_defines.svh"
module tbdc_core (
  input  logic               clk,
  input  logic               rst,
  input  tbdc_pkg::cfg_t     cfg,
  input  logic               s_valid,
  output logic               s_ready,
  input  tbdc_pkg::in_item_t s_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbdc_pkg::out_item_t out_data
);
  import tbdc_pkg::*;

  logic [7:0] divider_count, up_count, down_count;
  logic       up_state, down_state, up_edge_seen, down_edge_seen;
  logic       chord_edge_seen, both_counting;

  logic [7:0] divider_dec, divider_count_next, up_count_next, down_count_next;
  logic       update;
  logic       up_state_next, down_state_next, up_edge_seen_next, down_edge_seen_next;
  logic       chord_edge_seen_next, both_counting_next;
  logic       open_p, close_p, toggle_p;
  logic       load;

  function automatic logic [7:0] integrate(logic [7:0] cnt, logic pressed, logic [7:0] limit);
    logic [7:0] r;
    r = cnt;
    if (pressed) begin
      if (cnt < limit) r = cnt + 8'd1;
    end else if (cnt != 8'd0) begin
      r = cnt - 8'd1;
    end
    return r;
  endfunction

  assign s_ready = !out_valid || out_ready;
  assign load    = s_valid && s_ready;

  always_comb begin
    divider_dec = (s_data.tick && divider_count != 8'd0) ? divider_count - 8'd1
                                                         : divider_count;
    update             = (divider_dec == 8'd0);
    divider_count_next = update ? cfg.divider_reload : divider_dec;
    up_count_next      = update ? integrate(up_count, s_data.up_level, cfg.filter_limit)
                                : up_count;
    down_count_next    = update ? integrate(down_count, s_data.down_level, cfg.filter_limit)
                                : down_count;

    up_state_next     = up_state;
    up_edge_seen_next = up_edge_seen;
    open_p            = 1'b0;
    if (up_count_next == cfg.filter_limit) begin
      up_state_next = 1'b1;
      if (!up_edge_seen && !both_counting) begin
        up_edge_seen_next = 1'b1;
        open_p            = 1'b1;
      end
    end else if (up_count_next == 8'd0) begin
      up_state_next     = 1'b0;
      up_edge_seen_next = 1'b0;
    end

    down_state_next     = down_state;
    down_edge_seen_next = down_edge_seen;
    close_p             = 1'b0;
    if (down_count_next == cfg.filter_limit) begin
      down_state_next = 1'b1;
      if (!down_edge_seen && !both_counting) begin
        down_edge_seen_next = 1'b1;
        close_p             = 1'b1;
      end
    end else if (down_count_next == 8'd0) begin
      down_state_next     = 1'b0;
      down_edge_seen_next = 1'b0;
    end

    both_counting_next = (up_count_next != 8'd0) && (down_count_next != 8'd0);

    chord_edge_seen_next = chord_edge_seen;
    toggle_p             = 1'b0;
    if (up_state_next && down_state_next) begin
      if (!chord_edge_seen) begin
        chord_edge_seen_next = 1'b1;
        toggle_p             = 1'b1;
      end
    end else if (!up_state_next && !down_state_next) begin
      chord_edge_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count   <= DIVIDER_RELOAD_RESET;
      up_count        <= 8'd0;
      down_count      <= 8'd0;
      up_state        <= 1'b0;
      down_state      <= 1'b0;
      up_edge_seen    <= 1'b0;
      down_edge_seen  <= 1'b0;
      chord_edge_seen <= 1'b0;
      both_counting   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (load) begin
        divider_count   <= divider_count_next;
        up_count        <= up_count_next;
        down_count      <= down_count_next;
        up_state        <= up_state_next;
        down_state      <= down_state_next;
        up_edge_seen    <= up_edge_seen_next;
        down_edge_seen  <= down_edge_seen_next;
        chord_edge_seen <= chord_edge_seen_next;
        both_counting   <= both_counting_next;
      end
      if (s_ready) begin
        out_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.up_held      <= up_state_next;
      out_data.down_held    <= down_state_next;
      out_data.open_pulse   <= open_p;
      out_data.close_pulse  <= close_p;
      out_data.toggle_pulse <= toggle_p;
      out_data.chord_held   <= chord_edge_seen_next;
    end
  end

  `TBDC_ASSERT_IMP(a_up_edge_held, clk, rst, up_edge_seen, up_state)
  `TBDC_ASSERT_IMP(a_chord_needs_held, clk, rst, chord_edge_seen, up_state || down_state)
  `TBDC_ASSERT_IMP(a_open_with_held, clk, rst, out_valid && out_data.open_pulse,
                   out_data.up_held)
  `TBDC_ASSERT_NXT(a_open_marks_edge, clk, rst, load && open_p, up_edge_seen)

endmodule

>>> src/two_button_debounce_chord.sv
`timescale 1ns / 1ps
// Two-button debouncer with chord detection.
// Input channel (in_valid/in_ready/in_data): one transaction per handler pass,
// carrying the millisecond tick flag and the up and down pin levels.
// Output channel (out_valid/out_ready/out_data): exactly one result transaction
// per input transaction, in order: debounced held states, open/close press
// pulses, toggle pulse and chord held flag.
// Path: input register, then the update logic into the result register.
// Throughput: one transaction per cycle while out_ready stays high; the state
// update between the two registers is combinational.
// Configuration: cfg_wr_en/cfg_index/cfg_data write divider_reload (index 0)
// and filter_limit (index 1); write only while no transaction is in flight.
// Reset (rst, synchronous): divider_reload 10, filter_limit 5, divider counter
// loaded with 10, button counters and flags cleared, both channels empty.
// When the receiver stalls, the result register holds and one further
// transaction is taken into the input register; in_ready then drops.
module two_button_debounce_chord (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbdc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tbdc_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import tbdc_pkg::*;

  cfg_t     cfg;
  logic     s_valid, s_ready;
  in_item_t s_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.divider_reload <= DIVIDER_RELOAD_RESET;
      cfg.filter_limit   <= FILTER_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIVIDER_RELOAD: cfg.divider_reload <= cfg_data;
        REG_FILTER_LIMIT:   cfg.filter_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  tbdc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data)
  );

  tbdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/two_button_debounce_chord_tb.sv
`timescale 1ns / 1ps
module two_button_debounce_chord_tb;
  import tbdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP = 100;

  typedef enum bit {ROW_PASS, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic       index;
    logic [7:0] value;
    in_item_t   pass;
    bit         typed;
    out_item_t  want;
  } script_row_t;

  typedef struct {
    logic [7:0] reload;
    logic [7:0] limit;
    int         passes;
  } phase_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_index;
  logic [7:0] cfg_data;

  two_button_debounce_chord dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // debouncer state mirrored by the predictor
  logic [7:0] model_reload;
  logic [7:0] model_limit;
  logic [7:0] div_left;
  logic [7:0] up_cnt;
  logic [7:0] dn_cnt;
  logic       up_hold;
  logic       dn_hold;
  logic       up_pulsed;
  logic       dn_pulsed;
  logic       chord_latched;
  logic       both_active;

  out_item_t pending_results [$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        sent = 0;
  int        received = 0;
  bit        drive_quiet = 1'b0;
  bit        accept_quiet = 1'b0;
  int        stall;
  int        burst_left = 0;
  logic      burst_up;
  logic      burst_dn;

  script_row_t script [24] = '{
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b011, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b111, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b000, 1'b1, 6'b000000},
    '{ROW_WRITE, REG_DIVIDER_RELOAD, 8'd0,   3'b000, 1'b0, 6'b000000},
    '{ROW_WRITE, REG_FILTER_LIMIT,   8'd1,   3'b000, 1'b0, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b100, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b010, 1'b1, 6'b101000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b011, 1'b1, 6'b110111},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b001, 1'b1, 6'b010001},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b011, 1'b1, 6'b111001},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b000, 1'b1, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b111, 1'b1, 6'b111111},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b111, 1'b1, 6'b110001},
    '{ROW_WRITE, REG_FILTER_LIMIT,   8'd0,   3'b000, 1'b0, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b000, 1'b0, 6'b000000},
    '{ROW_PASS,  REG_DIVIDER_RELOAD, 8'd0,   3'b010, 1'b0, 6'b000000}
  };

  phase_t plan [8] = '{
    '{8'd0,   8'd12,  60},
    '{8'd0,   8'd3,   50},
    '{8'd1,   8'd2,   70},
    '{8'd2,   8'd4,   70},
    '{8'd255, 8'd255, 30},
    '{8'd0,   8'd1,   60},
    '{8'd3,   8'd0,   40},
    '{8'd10,  8'd5,   60}
  };

  function automatic logic [7:0] step_count(input logic [7:0] cnt, input logic pressed);
    if (pressed) begin
      if (cnt < model_limit) return cnt + 8'd1;
    end else if (cnt != 8'd0) begin
      return cnt - 8'd1;
    end
    return cnt;
  endfunction

  function automatic logic settle_button(input logic [7:0] cnt, inout logic held,
                                         inout logic pulsed, input logic blocked);
    if (cnt == model_limit) begin
      held = 1'b1;
      if (!pulsed && !blocked) begin
        pulsed = 1'b1;
        return 1'b1;
      end
    end else if (cnt == 8'd0) begin
      held = 1'b0;
      pulsed = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t debounce_pass(input in_item_t pass);
    out_item_t res;
    if (pass.tick && div_left != 8'd0) div_left = div_left - 8'd1;
    if (div_left == 8'd0) begin
      div_left = model_reload;
      up_cnt = step_count(up_cnt, pass.up_level);
      dn_cnt = step_count(dn_cnt, pass.down_level);
    end
    res.open_pulse = settle_button(up_cnt, up_hold, up_pulsed, both_active);
    res.close_pulse = settle_button(dn_cnt, dn_hold, dn_pulsed, both_active);
    both_active = (up_cnt != 8'd0) && (dn_cnt != 8'd0);
    res.toggle_pulse = 1'b0;
    if (up_hold && dn_hold) begin
      if (!chord_latched) begin
        chord_latched = 1'b1;
        res.toggle_pulse = 1'b1;
      end
    end else if (!up_hold && !dn_hold) begin
      chord_latched = 1'b0;
    end
    res.up_held = up_hold;
    res.down_held = dn_hold;
    res.chord_held = chord_latched;
    return res;
  endfunction

  function automatic in_item_t next_random_pass();
    in_item_t pass;
    if (burst_left == 0) begin
      burst_up = 1'($urandom_range(0, 1));
      burst_dn = 1'($urandom_range(0, 1));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pass.tick = ($urandom_range(0, 3) != 0);
    pass.up_level = burst_up;
    pass.down_level = burst_dn;
    if ($urandom_range(0, 9) == 0) pass.up_level = ~pass.up_level;
    if ($urandom_range(0, 9) == 0) pass.down_level = ~pass.down_level;
    return pass;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_bit(input string name, input logic got, input logic want);
    if (got !== want) report($sformatf("%s got %b want %b", name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result %b with no transaction outstanding", got));
      return;
    end
    want = pending_results.pop_front();
    check_bit("up_held", got.up_held, want.up_held);
    check_bit("down_held", got.down_held, want.down_held);
    check_bit("open_pulse", got.open_pulse, want.open_pulse);
    check_bit("close_pulse", got.close_pulse, want.close_pulse);
    check_bit("toggle_pulse", got.toggle_pulse, want.toggle_pulse);
    check_bit("chord_held", got.chord_held, want.chord_held);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_pass(input in_item_t pass, input bit typed, input out_item_t want);
    int gap;
    out_item_t predicted;
    if (sent % 16 == 0) drive_quiet = ($urandom_range(0, 3) == 0);
    sent++;
    gap = drive_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= pass;
    do @(posedge clk); while (!in_ready);
    predicted = debounce_pass(pass);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic index, input logic [7:0] value);
    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == REG_DIVIDER_RELOAD) model_reload = value;
    else model_limit = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // drain results with random back-pressure
  initial begin
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (received % 16 == 0) accept_quiet = ($urandom_range(0, 3) == 0);
      stall = accept_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
      received++;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DIVIDER_RELOAD;
    cfg_data = '0;
    model_reload = DIVIDER_RELOAD_RESET;
    model_limit = FILTER_LIMIT_RESET;
    div_left = DIVIDER_RELOAD_RESET;
    up_cnt = '0;
    dn_cnt = '0;
    up_hold = 1'b0;
    dn_hold = 1'b0;
    up_pulsed = 1'b0;
    dn_pulsed = 1'b0;
    chord_latched = 1'b0;
    both_active = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) write_reg(script[i].index, script[i].value);
      else send_pass(script[i].pass, script[i].typed, script[i].want);
    end

    foreach (plan[p]) begin
      write_reg(REG_DIVIDER_RELOAD, plan[p].reload);
      write_reg(REG_FILTER_LIMIT, plan[p].limit);
      repeat (plan[p].passes) send_pass(next_random_pass(), 1'b0, '0);
    end

    hold_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
